// File: hw/rtl/fpfe_pkg.sv
package fpfe_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;

    localparam int unsigned GEOM_W = 9;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned PAT_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_PATTERN = 2'd2;

    localparam logic [GEOM_W-1:0] RST_FRAME_WIDTH  = 9'd256;
    localparam logic [GEOM_W-1:0] RST_FRAME_HEIGHT = 9'd256;
    localparam logic [PAT_W-1:0]  RST_FILL_PATTERN = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_SET   = 2'd0,
        KIND_RECT  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_BASE,
        ST_WALK,
        ST_READ,
        ST_RDWAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [COLOR_W-1:0] color;
    } t_cmd;

    typedef struct packed {
        logic [GEOM_W-1:0] frame_width;
        logic [GEOM_W-1:0] frame_height;
        logic [PAT_W-1:0]  fill_pattern;
    } t_cfg;

    typedef struct packed {
        logic               idle;
        logic               done;
        logic [COLOR_W-1:0] pixel;
    } t_wstat;

endpackage

// File: hw/rtl/fpfe_ram.sv
module fpfe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/fpfe_walker.sv
module fpfe_walker #(
    parameter int unsigned MAX_WIDTH  = fpfe_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = fpfe_pkg::DEF_MAX_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  fpfe_pkg::t_cmd   i_cmd,
    input  fpfe_pkg::t_cfg   i_cfg,
    input  logic             i_out_free,
    output fpfe_pkg::t_wstat o_stat
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned GW = fpfe_pkg::GEOM_W;
    localparam int unsigned SW = 18;
    localparam logic [31:0] MW = MAX_WIDTH;
    localparam logic [31:0] MH = MAX_HEIGHT;

    fpfe_pkg::t_state r_state, n_state;
    fpfe_pkg::t_cmd   r_cmd;
    logic [GW-1:0]    r_x0, r_x1, r_y1, r_col, r_row;
    logic [GW-1:0]    n_x0, n_x1, n_y0, n_y1;
    logic             r_empty, n_empty;
    logic [AW-1:0]    r_base;
    logic [fpfe_pkg::COLOR_W-1:0] r_pixel;

    logic [GW-1:0]    act_w, act_h;
    logic signed [SW-1:0] sx, sy, sw, sh, fw_s, fh_s;
    logic signed [SW-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [2*GW-1:0]  prod;
    logic [AW-1:0]    addr;
    logic             col_last, row_last, pat_on;
    logic             we, re;
    logic [fpfe_pkg::COLOR_W-1:0] rdata;

    // active area, clamped to the store geometry
    always_comb begin
        act_w = ({23'd0, i_cfg.frame_width} > MW) ? MW[GW-1:0] : i_cfg.frame_width;
        act_h = ({23'd0, i_cfg.frame_height} > MH) ? MH[GW-1:0] : i_cfg.frame_height;
    end

    // clip unit: command to a half-open pixel box
    always_comb begin
        sx   = SW'($signed(r_cmd.pos_x));
        sy   = SW'($signed(r_cmd.pos_y));
        sw   = SW'($signed(r_cmd.rect_width));
        sh   = SW'($signed(r_cmd.rect_height));
        fw_s = $signed({9'd0, act_w});
        fh_s = $signed({9'd0, act_h});
        lo_x = '0;
        hi_x = '0;
        lo_y = '0;
        hi_y = '0;
        n_empty = 1'b1;
        unique case (r_cmd.kind)
            fpfe_pkg::KIND_SET, fpfe_pkg::KIND_READ: begin
                lo_x = sx;
                hi_x = sx + SW'(1);
                lo_y = sy;
                hi_y = sy + SW'(1);
                n_empty = !(sx >= 0 && sx < fw_s && sy >= 0 && sy < fh_s);
            end
            fpfe_pkg::KIND_RECT: begin
                lo_x = (sx < 0) ? '0 : sx;
                lo_y = (sy < 0) ? '0 : sy;
                hi_x = (sx + sw > fw_s) ? fw_s : sx + sw;
                hi_y = (sy + sh > fh_s) ? fh_s : sy + sh;
                n_empty = !(sw > 0 && sh > 0 && hi_x > lo_x && hi_y > lo_y);
            end
            fpfe_pkg::KIND_CLEAR: begin
                hi_x = fw_s;
                hi_y = fh_s;
                n_empty = (act_w == '0) || (act_h == '0);
            end
            default: begin
                n_empty = 1'b1;
            end
        endcase
        n_x0 = lo_x[GW-1:0];
        n_x1 = hi_x[GW-1:0];
        n_y0 = lo_y[GW-1:0];
        n_y1 = hi_y[GW-1:0];
    end

    assign prod     = r_row * act_w;
    assign addr     = r_base + AW'(r_col);
    assign col_last = ({1'b0, r_col} + 10'd1) == {1'b0, r_x1};
    assign row_last = ({1'b0, r_row} + 10'd1) == {1'b0, r_y1};
    assign pat_on   = i_cfg.fill_pattern[{r_row[1:0], r_col[1:0]}];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpfe_pkg::ST_IDLE:   if (i_start) n_state = fpfe_pkg::ST_CLIP;
            fpfe_pkg::ST_CLIP:   n_state = fpfe_pkg::ST_BASE;
            fpfe_pkg::ST_BASE: begin
                if (r_empty) begin
                    n_state = fpfe_pkg::ST_DONE;
                end else if (r_cmd.kind == fpfe_pkg::KIND_READ) begin
                    n_state = fpfe_pkg::ST_READ;
                end else begin
                    n_state = fpfe_pkg::ST_WALK;
                end
            end
            fpfe_pkg::ST_WALK:   if (col_last && row_last) n_state = fpfe_pkg::ST_DONE;
            fpfe_pkg::ST_READ:   n_state = fpfe_pkg::ST_RDWAIT;
            fpfe_pkg::ST_RDWAIT: n_state = fpfe_pkg::ST_DONE;
            fpfe_pkg::ST_DONE:   if (i_out_free) n_state = fpfe_pkg::ST_IDLE;
            default:             n_state = fpfe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        we = 1'b0;
        re = 1'b0;
        o_stat = '0;
        unique case (r_state)
            fpfe_pkg::ST_IDLE: o_stat.idle = 1'b1;
            fpfe_pkg::ST_WALK: begin
                // clear ignores pattern and transparency
                we = (r_cmd.kind == fpfe_pkg::KIND_CLEAR) ||
                     ((r_cmd.color != '0) && pat_on);
            end
            fpfe_pkg::ST_READ: re = 1'b1;
            fpfe_pkg::ST_DONE: begin
                o_stat.done  = 1'b1;
                o_stat.pixel = r_pixel;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpfe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fpfe_pkg::ST_IDLE: begin
                if (i_start) begin
                    r_cmd   <= i_cmd;
                    r_pixel <= '0;
                end
            end
            fpfe_pkg::ST_CLIP: begin
                r_x0    <= n_x0;
                r_x1    <= n_x1;
                r_y1    <= n_y1;
                r_row   <= n_y0;
                r_empty <= n_empty;
            end
            fpfe_pkg::ST_BASE: begin
                r_base <= AW'(prod);
                r_col  <= r_x0;
            end
            fpfe_pkg::ST_WALK: begin
                if (col_last) begin
                    r_col  <= r_x0;
                    r_row  <= r_row + GW'(1);
                    r_base <= r_base + AW'(act_w);
                end else begin
                    r_col <= r_col + GW'(1);
                end
            end
            fpfe_pkg::ST_RDWAIT: r_pixel <= rdata;
            default: begin
                r_pixel <= r_pixel;
            end
        endcase
    end

    fpfe_ram #(
        .WIDTH (fpfe_pkg::COLOR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (r_cmd.color),
        .i_re    (re),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

endmodule

// File: hw/rtl/framebuffer_pattern_fill_engine_top.sv
// Indexed-color framebuffer drawing engine with a 4x4 fill pattern.
// Command items enter on the s-side stream: tuser carries the kind (set,
// rect fill, read, clear), tdata the coordinates, rectangle size and color.
// Every command returns exactly one item on the m-side stream: the stored
// pixel for a read, 0 for all other kinds.
// Geometry and pattern registers are written on the cfg channel (always ready);
// the user writes them while no command is in flight; the block does not check.
// Sequence: a command is accepted in idle, then passes the clip and base steps;
// a set, rectangle or clear then walks its covered pixels, a read issues the
// store read and waits for the data, and a command clipped to nothing goes
// straight to the done step, which registers the result into the output.
// Throughput is set by the single store write port: one pixel per cycle,
// one command at a time; s_tready rises together with the registered result.
// The result sits in an output register, so a new command is taken while
// the previous result waits; a stalled receiver holds the sequencer in its
// final step until the output register frees.
// Reset restores the register defaults and empties the output; pixel store
// contents are not cleared and read back undefined until written.
module framebuffer_pattern_fill_engine_top #(
    parameter int unsigned MAX_WIDTH  = fpfe_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = fpfe_pkg::DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // pos_x, pos_y, rect_width, rect_height, color
    input  logic [1:0]  s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // read_pixel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [fpfe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpfe_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    fpfe_pkg::t_cfg   r_cfg;
    fpfe_pkg::t_cmd   cmd;
    fpfe_pkg::t_wstat stat;
    logic             r_out_valid;
    logic [7:0]       r_out_data;
    logic             out_free;
    logic             start;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= fpfe_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height <= fpfe_pkg::RST_FRAME_HEIGHT;
            r_cfg.fill_pattern <= fpfe_pkg::RST_FILL_PATTERN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fpfe_pkg::CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[8:0];
                fpfe_pkg::CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[8:0];
                fpfe_pkg::CFG_FILL_PATTERN: r_cfg.fill_pattern <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign cmd.kind        = fpfe_pkg::t_kind'(s_tuser);
    assign cmd.pos_x       = s_tdata[15:0];
    assign cmd.pos_y       = s_tdata[31:16];
    assign cmd.rect_width  = s_tdata[47:32];
    assign cmd.rect_height = s_tdata[63:48];
    assign cmd.color       = s_tdata[71:64];

    assign s_tready = stat.idle;
    assign start    = s_tvalid && stat.idle;
    assign out_free = !r_out_valid || m_tready;

    fpfe_walker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (cmd),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_stat     (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.done && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done && out_free) begin
            r_out_data <= stat.pixel;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

// File: hw/rtl/fpfe_checker.sv
module fpfe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // one command at a time: the sequencer is busy right after taking one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("fpfe: command taken while sequencer busy");

    // m_tvalid stays low right after a command enters with no result pending
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("fpfe: result appeared too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("fpfe: result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("fpfe: result changed while stalled");

endmodule

bind framebuffer_pattern_fill_engine_top fpfe_checker u_fpfe_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
